>>> hw/rtl/pll_pkg.sv
// shared types, constants and lookup functions for the pack locator
package pll_pkg;

    localparam logic [15:0] SCAN_LIMIT_RESET = 16'd4096;
    localparam logic [3:0]  LINE_IDX_MAX     = 4'd10;
    localparam logic [15:0] HDR_LEN          = 16'd4;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DONE    = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic        found;
        logic [15:0] pack_start;
    } result_t;

    // low nibble is the digit value, top bit marks a valid hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic [7:0] magic_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0:    c = 8'h50; // P
            2'd1:    c = 8'h41; // A
            2'd2:    c = 8'h43; // C
            default: c = 8'h4b; // K
        endcase
        return c;
    endfunction

    // prefixes: 0 NAK\n, 1 "ACK ", 2 "shallow ", 3 "unshallow "
    function automatic logic [3:0] prefix_size(input logic [1:0] k);
        logic [3:0] n;
        unique case (k)
            2'd0:    n = 4'd4;
            2'd1:    n = 4'd4;
            2'd2:    n = 4'd8;
            default: n = 4'd10;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] prefix_char(input logic [1:0] k, input logic [3:0] idx);
        logic [7:0] c;
        c = 8'h00;
        unique case (k)
            2'd0: begin
                unique case (idx)
                    4'd0:    c = 8'h4e; // N
                    4'd1:    c = 8'h41; // A
                    4'd2:    c = 8'h4b; // K
                    4'd3:    c = 8'h0a; // newline
                    default: c = 8'h00;
                endcase
            end
            2'd1: begin
                unique case (idx)
                    4'd0:    c = 8'h41; // A
                    4'd1:    c = 8'h43; // C
                    4'd2:    c = 8'h4b; // K
                    4'd3:    c = 8'h20;
                    default: c = 8'h00;
                endcase
            end
            2'd2: begin
                unique case (idx)
                    4'd0:    c = 8'h73; // s
                    4'd1:    c = 8'h68; // h
                    4'd2:    c = 8'h61; // a
                    4'd3:    c = 8'h6c; // l
                    4'd4:    c = 8'h6c; // l
                    4'd5:    c = 8'h6f; // o
                    4'd6:    c = 8'h77; // w
                    4'd7:    c = 8'h20;
                    default: c = 8'h00;
                endcase
            end
            default: begin
                unique case (idx)
                    4'd0:    c = 8'h75; // u
                    4'd1:    c = 8'h6e; // n
                    4'd2:    c = 8'h73; // s
                    4'd3:    c = 8'h68; // h
                    4'd4:    c = 8'h61; // a
                    4'd5:    c = 8'h6c; // l
                    4'd6:    c = 8'h6c; // l
                    4'd7:    c = 8'h6f; // o
                    4'd8:    c = 8'h77; // w
                    4'd9:    c = 8'h20;
                    default: c = 8'h00;
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

>>> hw/rtl/pkt_line_pack_locator.sv
// top level of the pkt-line pack start locator
//
// Takes a response body one byte per word on the s_ channel (s_data_byte,
// s_last_byte) and reports where raw pack data begins on the m_ channel
// (m_found, m_pack_start). Each response yields exactly one result word: at
// the byte where the decision is made, or at the byte flagged s_last_byte.
// Bytes after a decision are consumed silently until the last byte.
// Throughput is one byte per cycle while the receiver is not stalling; a byte
// passes the input register, the parser logic and the result register, and
// its result word then shows on m_valid.
// The cfg channel writes scan_limit (reset 4096); write it only while no
// response is in flight. cfg_ready is always high.
// aresetn is synchronous and active low; it empties both registers, sets
// scan_limit back to 4096 and puts the parser at the start of a response.
// When the receiver stalls, the result word holds and the parser waits, even
// on bytes that give no result; the input register takes one more byte and
// s_ready then stays low until the receiver takes the result word.
module pkt_line_pack_locator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [15:0] m_pack_start,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic [15:0]      limit_reg, limit_next;
    logic             item_valid;
    pll_pkg::item_t   item;
    logic             out_free;
    logic             step;
    logic             res_valid;
    pll_pkg::result_t res;

    assign cfg_ready = 1'b1;

    always_comb begin
        limit_next = limit_reg;
        if (cfg_valid && cfg_ready) begin
            limit_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= pll_pkg::SCAN_LIMIT_RESET;
        end else begin
            limit_reg <= limit_next;
        end
    end

    // a word moves into the parser only when its result has somewhere to go
    assign step = item_valid && out_free;

    pll_in_stage u_in_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .take        (out_free),
        .item_valid  (item_valid),
        .item        (item)
    );

    pll_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .item       (item),
        .scan_limit (limit_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    pll_out_stage u_out_stage (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (res_valid),
        .res          (res),
        .out_free     (out_free),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_found      (m_found),
        .m_pack_start (m_pack_start)
    );

endmodule

>>> hw/rtl/pll_in_stage.sv
// input register holding one word ahead of the parser
module pll_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_data_byte,
    input  logic            s_last_byte,
    input  logic            take,
    output logic            item_valid,
    output pll_pkg::item_t  item
);

    logic           in_valid_reg, in_valid_next;
    pll_pkg::item_t in_item_reg, in_item_next;
    logic           s_fire;

    assign s_ready = !in_valid_reg || take;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
            in_item_next  = '{data_byte: s_data_byte, last_byte: s_last_byte};
        end else if (take) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        in_item_reg <= in_item_next;
    end

    assign item_valid = in_valid_reg;
    assign item       = in_item_reg;

`ifndef SYNTHESIS
    // a held word that the parser did not take stays put
    a_hold_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !take |=> in_valid_reg && $stable(in_item_reg))
        else $error("input word changed before it was taken");
`endif

endmodule

>>> hw/rtl/pll_parser.sv
// pkt-line deframer state and the per-word decision logic
module pll_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  pll_pkg::item_t    item,
    input  logic [15:0]       scan_limit,
    output logic              res_valid,
    output pll_pkg::result_t  res
);

    pll_pkg::phase_t phase_reg, phase_next;
    logic [1:0]  hdr_count_reg, hdr_count_next;
    logic [15:0] len_reg, len_next;
    logic        hdr_is_pack_reg, hdr_is_pack_next;
    logic        hdr_is_hex_reg, hdr_is_hex_next;
    logic [15:0] left_reg, left_next;
    logic [3:0]  line_idx_reg, line_idx_next;
    logic [3:0]  alive_reg, alive_next;
    logic [16:0] pos_reg, pos_next;

    logic [7:0]  b;
    logic [4:0]  hex;
    logic        limit_hit;
    logic        is_pack_w;
    logic        is_hex_w;
    logic [15:0] len_w;
    logic        hdr_end;
    logic        hdr_bad;
    logic [3:0]  alive_w;
    logic [3:0]  complete_w;
    logic [3:0]  line_idx_w;
    logic [15:0] left_w;
    logic        line_ok;
    logic        hdr_decide;
    logic        pay_decide;
    logic        decided_w;
    logic        found_w;

    assign b          = item.data_byte;
    assign hex        = pll_pkg::hex_value(b);
    assign limit_hit  = (hdr_count_reg == 2'd0) && (pos_reg >= {1'b0, scan_limit});
    assign is_pack_w  = hdr_is_pack_reg && (b == pll_pkg::magic_char(hdr_count_reg));
    assign is_hex_w   = hdr_is_hex_reg && hex[4];
    assign len_w      = {len_reg[11:0], hex[3:0]};
    assign hdr_end    = (hdr_count_reg == 2'd3);
    // lengths 1 to 4 leave no room for any prefix
    assign hdr_bad    = !is_hex_w || ((len_w != 16'd0) && (len_w <= pll_pkg::HDR_LEN));
    assign line_idx_w = (line_idx_reg < pll_pkg::LINE_IDX_MAX) ? line_idx_reg + 4'd1
                                                               : line_idx_reg;
    assign left_w     = left_reg - 16'd1;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            alive_w[k] = alive_reg[k];
            if (line_idx_reg < pll_pkg::prefix_size(2'(k)) &&
                b != pll_pkg::prefix_char(2'(k), line_idx_reg)) begin
                alive_w[k] = 1'b0;
            end
            complete_w[k] = (line_idx_w >= pll_pkg::prefix_size(2'(k)));
        end
    end

    assign line_ok    = |(alive_w & complete_w);
    assign hdr_decide = (phase_reg == pll_pkg::PH_HEADER) &&
                        (limit_hit || (hdr_end && (is_pack_w || hdr_bad)));
    assign pay_decide = (phase_reg == pll_pkg::PH_PAYLOAD) && (left_w == 16'd0) && !line_ok;
    assign decided_w  = hdr_decide || pay_decide;
    assign found_w    = (phase_reg == pll_pkg::PH_HEADER) && !limit_hit && hdr_end && is_pack_w;

    // next state
    always_comb begin
        phase_next       = phase_reg;
        hdr_count_next   = hdr_count_reg;
        len_next         = len_reg;
        hdr_is_pack_next = hdr_is_pack_reg;
        hdr_is_hex_next  = hdr_is_hex_reg;
        left_next        = left_reg;
        line_idx_next    = line_idx_reg;
        alive_next       = alive_reg;
        pos_next         = pos_reg;
        if (step) begin
            unique case (phase_reg)
                pll_pkg::PH_HEADER: begin
                    if (!limit_hit) begin
                        hdr_count_next = hdr_count_reg + 2'd1;
                        if (hdr_end) begin
                            len_next         = 16'd0;
                            hdr_is_pack_next = 1'b1;
                            hdr_is_hex_next  = 1'b1;
                            if (!is_pack_w && !hdr_bad && len_w != 16'd0) begin
                                left_next     = len_w - pll_pkg::HDR_LEN;
                                line_idx_next = 4'd0;
                                alive_next    = 4'hf;
                                phase_next    = pll_pkg::PH_PAYLOAD;
                            end
                        end else begin
                            len_next         = len_w;
                            hdr_is_pack_next = is_pack_w;
                            hdr_is_hex_next  = is_hex_w;
                        end
                    end
                end
                pll_pkg::PH_PAYLOAD: begin
                    alive_next    = alive_w;
                    line_idx_next = line_idx_w;
                    left_next     = left_w;
                    if (left_w == 16'd0 && line_ok) begin
                        phase_next = pll_pkg::PH_HEADER;
                    end
                end
                default: begin
                end
            endcase
            if (pos_reg != '1) begin
                pos_next = pos_reg + 17'd1;
            end
            if (decided_w) begin
                phase_next = pll_pkg::PH_DONE;
            end
            // end of response rearms the parser
            if (item.last_byte) begin
                phase_next       = pll_pkg::PH_HEADER;
                hdr_count_next   = 2'd0;
                len_next         = 16'd0;
                hdr_is_pack_next = 1'b1;
                hdr_is_hex_next  = 1'b1;
                left_next        = 16'd0;
                line_idx_next    = 4'd0;
                alive_next       = 4'hf;
                pos_next         = 17'd0;
            end
        end
    end

    // result for this word
    always_comb begin
        res_valid = step && (decided_w ||
                    (item.last_byte && phase_reg != pll_pkg::PH_DONE));
        res.found      = decided_w && found_w;
        res.pack_start = (decided_w && found_w) ? pos_reg[15:0] - 16'd3 : 16'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= pll_pkg::PH_HEADER;
            hdr_count_reg   <= 2'd0;
            len_reg         <= 16'd0;
            hdr_is_pack_reg <= 1'b1;
            hdr_is_hex_reg  <= 1'b1;
            left_reg        <= 16'd0;
            line_idx_reg    <= 4'd0;
            alive_reg       <= 4'hf;
            pos_reg         <= 17'd0;
        end else begin
            phase_reg       <= phase_next;
            hdr_count_reg   <= hdr_count_next;
            len_reg         <= len_next;
            hdr_is_pack_reg <= hdr_is_pack_next;
            hdr_is_hex_reg  <= hdr_is_hex_next;
            left_reg        <= left_next;
            line_idx_reg    <= line_idx_next;
            alive_reg       <= alive_next;
            pos_reg         <= pos_next;
        end
    end

`ifndef SYNTHESIS
    a_rearm: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.last_byte |=> phase_reg == pll_pkg::PH_HEADER && pos_reg == 17'd0)
        else $error("parser not rearmed after last word");

    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res.found |-> res.pack_start == 16'd0)
        else $error("offset reported without a pack start");

    a_quiet_when_done: assert property (@(posedge aclk) disable iff (!aresetn)
        step && phase_reg == pll_pkg::PH_DONE && !item.last_byte |-> !res_valid)
        else $error("second result within one response");

    a_header_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == pll_pkg::PH_PAYLOAD |-> hdr_count_reg == 2'd0 && left_reg != 16'd0)
        else $error("payload phase entered mid-header or with no bytes left");
`endif

endmodule

>>> hw/rtl/pll_out_stage.sv
// result register toward the receiver
module pll_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  pll_pkg::result_t  res,
    output logic              out_free,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_found,
    output logic [15:0]       m_pack_start
);

    logic             m_valid_reg, m_valid_next;
    pll_pkg::result_t res_reg, res_next;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        res_next     = res_reg;
        if (load) begin
            m_valid_next = 1'b1;
            res_next     = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        res_reg <= res_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_found      = res_reg.found;
    assign m_pack_start = res_reg.pack_start;

endmodule

>>> verif/tb_pkt_line_pack_locator.sv
// self-checking testbench for the pkt-line pack start locator
module tb_pkt_line_pack_locator;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int          RANDOM_BYTES  = 1000;
    localparam int          PHASES        = 10;
    localparam int          DRAIN_LIMIT   = 4000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          LONG_HOLD     = 200;
    localparam int          HOLD_AFTER    = 700;

    // directed table: bit 17 marks a typed-in verdict, bit 16 found, low 16 pack_start
    localparam logic [17:0] NO_CHECK = 18'h0_0000;
    localparam logic [17:0] MISS     = 18'h2_0000;
    localparam logic [17:0] FOUND_AT = 18'h3_0000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_last_byte;
    logic        m_valid;
    logic        m_ready;
    logic        m_found;
    logic [15:0] m_pack_start;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    pkt_line_pack_locator dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_last_byte  (s_last_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_found      (m_found),
        .m_pack_start (m_pack_start),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    string magic_word;
    string prefix_word [4];

    // locator state as predicted
    logic [15:0]      scan_stop;
    pll_pkg::phase_t  parse_phase;
    logic [1:0]       hdr_count;
    logic [15:0]      len_acc;
    logic             hdr_is_pack;
    logic             hdr_is_hex;
    logic [15:0]      line_left;
    logic [3:0]       line_pos;
    logic [3:0]       prefix_ok;
    logic [16:0]      byte_pos;

    pll_pkg::result_t pending_locates [$];
    logic [16:0]      last_verdict;
    logic [7:0]       resp_q [$];
    string            frame_text [$];
    logic [17:0]      frame_want [$];

    int          fails;
    int          items_taken;
    int unsigned cycle_count;
    int          tx_idle_pct;
    int          rx_idle_pct;
    bit          quiet;
    bit          long_hold_done;
    int          stall_left;

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return "0" + n;
        if ($urandom_range(0, 1) == 0) return "A" + (n - 4'd10);
        return "a" + (n - 4'd10);
    endfunction

    function automatic void clear_parse();
        parse_phase = pll_pkg::PH_HEADER;
        hdr_count   = 2'd0;
        len_acc     = 16'd0;
        hdr_is_pack = 1'b1;
        hdr_is_hex  = 1'b1;
        line_left   = 16'd0;
        line_pos    = 4'd0;
        prefix_ok   = 4'hF;
        byte_pos    = 17'd0;
    endfunction

    task automatic locate_step(input logic [7:0] b, input logic last,
                               output bit decided, output pll_pkg::result_t res);
        logic [16:0] pos;
        int          dig;
        logic [3:0]  complete;
        pos     = byte_pos;
        decided = 1'b0;
        res     = '0;
        if (parse_phase == pll_pkg::PH_HEADER) begin
            if (hdr_count == 2'd0 && pos >= {1'b0, scan_stop}) begin
                decided = 1'b1;
            end else begin
                dig = hex_digit(b);
                if (b != magic_word[hdr_count]) hdr_is_pack = 1'b0;
                if (dig < 0) begin
                    hdr_is_hex = 1'b0;
                    dig = 0;
                end
                len_acc   = {len_acc[11:0], 4'(dig)};
                hdr_count = hdr_count + 2'd1;
                if (hdr_count == 2'd0) begin
                    if (hdr_is_pack) begin
                        decided        = 1'b1;
                        res.found      = 1'b1;
                        res.pack_start = 16'(pos - 17'd3);
                    end else if (!hdr_is_hex) begin
                        decided = 1'b1;
                    end else if (len_acc == 16'd0) begin
                        // flush, another header follows
                    end else if (len_acc <= pll_pkg::HDR_LEN) begin
                        decided = 1'b1;
                    end else begin
                        line_left   = len_acc - pll_pkg::HDR_LEN;
                        line_pos    = 4'd0;
                        prefix_ok   = 4'hF;
                        parse_phase = pll_pkg::PH_PAYLOAD;
                    end
                    len_acc     = 16'd0;
                    hdr_is_pack = 1'b1;
                    hdr_is_hex  = 1'b1;
                end
            end
        end else if (parse_phase == pll_pkg::PH_PAYLOAD) begin
            for (int k = 0; k < 4; k++) begin
                if (line_pos < prefix_word[k].len() && b != prefix_word[k][line_pos])
                    prefix_ok[k] = 1'b0;
            end
            if (line_pos < pll_pkg::LINE_IDX_MAX) line_pos = line_pos + 4'd1;
            line_left = line_left - 16'd1;
            if (line_left == 16'd0) begin
                for (int k = 0; k < 4; k++) complete[k] = (line_pos >= prefix_word[k].len());
                if ((prefix_ok & complete) != 4'd0) parse_phase = pll_pkg::PH_HEADER;
                else decided = 1'b1;
            end
        end
        if (byte_pos != '1) byte_pos = byte_pos + 17'd1;
        if (decided) parse_phase = pll_pkg::PH_DONE;
        if (last) begin
            // a response that ran out before any verdict still reports not-found
            if (!decided && parse_phase != pll_pkg::PH_DONE) decided = 1'b1;
            clear_parse();
        end
    endtask

    function automatic void push_header(input logic [15:0] len);
        for (int j = 3; j >= 0; j--) resp_q.insert(resp_q.size(), hex_char(len[4*j +: 4]));
    endfunction

    // mostly well-formed preambles with random content, some broken ones and noise
    function automatic void make_response();
        int          kind;
        int          k;
        int          extra;
        int          base;
        int          cut;
        logic [15:0] len;
        resp_q.delete();
        if ($urandom_range(0, 99) < 8) begin
            repeat ($urandom_range(1, 10)) resp_q.insert(resp_q.size(), 8'($urandom));
            return;
        end
        repeat ($urandom_range(0, 3)) begin
            kind  = $urandom_range(0, 99);
            k     = $urandom_range(0, 3);
            extra = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 8);
            len   = 16'(pll_pkg::HDR_LEN + prefix_word[k].len() + extra);
            if (kind < 12) begin
                push_header(16'd0);
            end else if (kind < 15) begin
                push_header(16'($urandom_range(1, 4)));
            end else begin
                if (kind < 18)
                    len = 16'(pll_pkg::HDR_LEN +
                              $urandom_range(0, prefix_word[k].len() - 1));
                push_header(len);
                if (kind >= 18 && kind < 21)
                    resp_q[resp_q.size() - 1 - $urandom_range(0, 3)] = 8'($urandom);
                base = resp_q.size();
                for (int j = 0; j < len - pll_pkg::HDR_LEN; j++) begin
                    if (j < prefix_word[k].len())
                        resp_q.insert(resp_q.size(), prefix_word[k][j]);
                    else if ($urandom_range(0, 4) == 0)
                        resp_q.insert(resp_q.size(), 8'($urandom));
                    else
                        resp_q.insert(resp_q.size(), 8'($urandom_range(32, 126)));
                end
                if (kind >= 21 && kind < 24 && len > pll_pkg::HDR_LEN)
                    resp_q[base + $urandom_range(0, len - pll_pkg::HDR_LEN - 1)] = 8'($urandom);
            end
        end
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            for (int j = 0; j < 4; j++) resp_q.insert(resp_q.size(), magic_word[j]);
            repeat ($urandom_range(0, 4)) resp_q.insert(resp_q.size(), 8'($urandom));
        end else if (kind < 75) begin
            for (int j = 0; j < 3; j++) resp_q.insert(resp_q.size(), magic_word[j]);
            resp_q.insert(resp_q.size(), 8'($urandom));
        end else if (kind < 90 && resp_q.size() > 1) begin
            cut = $urandom_range(1, (resp_q.size() > 6) ? 6 : resp_q.size() - 1);
            repeat (cut) resp_q.delete(resp_q.size() - 1);
        end
        if (resp_q.size() == 0) resp_q.insert(0, 8'($urandom));
    endfunction

    task automatic row(input string text, input logic [17:0] want);
        frame_text.insert(frame_text.size(), text);
        frame_want.insert(frame_want.size(), want);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!quiet && $urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // entered at a falling edge with s_valid already low
    task automatic settle();
        while (pending_locates.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    always @(posedge aclk) begin : monitor
        bit               hit;
        pll_pkg::result_t res;
        pll_pkg::result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                locate_step(s_data_byte, s_last_byte, hit, res);
                items_taken++;
                if (hit) begin
                    pending_locates.insert(pending_locates.size(), res);
                    last_verdict = {res.found, res.pack_start};
                end
            end
            if (m_valid && m_ready) begin
                if (pending_locates.size() == 0) begin
                    $display("%0t: unexpected word found=%0b pack_start=%0d",
                             $time, m_found, m_pack_start);
                    fails++;
                end else begin
                    want = pending_locates.pop_front();
                    if (m_found !== want.found) begin
                        $display("%0t: found expected %0b got %0b", $time, want.found, m_found);
                        fails++;
                    end
                    if (m_pack_start !== want.pack_start) begin
                        $display("%0t: pack_start expected %0d got %0d",
                                 $time, want.pack_start, m_pack_start);
                        fails++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) scan_stop = cfg_data;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run stopped at cycle %0d", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side back-pressure, with one long hold-off while bytes keep coming
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                stall_left--;
            end else if (!long_hold_done && items_taken >= HOLD_AFTER) begin
                stall_left     = LONG_HOLD;
                long_hold_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 99) < rx_idle_pct) begin
                stall_left = $urandom_range(1, 7);
            end
            m_ready <= (stall_left == 0);
        end
    end

    initial begin
        int          phase_bytes;
        int          drained;
        logic [15:0] limit_pick;
        s_valid        = 1'b0;
        s_data_byte    = 8'd0;
        s_last_byte    = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = 16'd0;
        aresetn        = 1'b0;
        fails          = 0;
        items_taken    = 0;
        cycle_count    = 0;
        stall_left     = 0;
        long_hold_done = 1'b0;
        quiet          = 1'b0;
        tx_idle_pct    = 20;
        rx_idle_pct    = 20;
        magic_word     = "PACK";
        prefix_word[0] = "NAK\n";
        prefix_word[1] = "ACK ";
        prefix_word[2] = "shallow ";
        prefix_word[3] = "unshallow ";
        scan_stop      = pll_pkg::SCAN_LIMIT_RESET;
        clear_parse();

        row("PACK",                     FOUND_AT + 18'd0);
        row("0000PACK",                 FOUND_AT + 18'd4);
        row("0000",                     MISS);
        row("0001",                     MISS);
        row("0003",                     MISS);
        row("0004",                     MISS);
        row("0008NAK\nPACK",            FOUND_AT + 18'd8);
        row("0008ACK PACK",             FOUND_AT + 18'd8);
        row("000cshallow PACK",         FOUND_AT + 18'd12);
        row("000Eunshallow PACK",       FOUND_AT + 18'd14);
        row("0010ACK 01234567PACK",     NO_CHECK);
        row("000bNAK\nxyzPACK",         NO_CHECK);
        row("000fUNSHALLOW abc",        NO_CHECK);
        row("0009shallow",              NO_CHECK);
        row("0007NAK",                  MISS);
        row("0008NAK\n",                MISS);
        row("0x08NAK\n",                MISS);
        row(" 008",                     MISS);
        row("+008",                     MISS);
        row("00G8",                     MISS);
        row("00",                       MISS);
        row("PAC",                      MISS);
        row("PACKPACK",                 FOUND_AT + 18'd0);
        row("0005\377",                 MISS);
        row("\200\177\001\376",         MISS);
        row("0000FFFF",                 NO_CHECK);

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // runs at the reset value of the limit
        for (int i = 0; i < frame_text.size(); i++) begin
            last_verdict = 'x;
            for (int j = 0; j < frame_text[i].len(); j++)
                send_byte(frame_text[i][j], j == frame_text[i].len() - 1);
            if (frame_want[i][17] && last_verdict !== frame_want[i][16:0]) begin
                $display("%0t: frame %0d expected found=%0b pack_start=%0d predicted %0b/%0d",
                         $time, i, frame_want[i][16], frame_want[i][15:0],
                         last_verdict[16], last_verdict[15:0]);
                fails++;
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            s_valid <= 1'b0;
            settle();
            case (p)
                0:       limit_pick = 16'd1;
                1:       limit_pick = 16'd0;
                2:       limit_pick = 16'hFFFF;
                3:       limit_pick = 16'd7;
                4:       limit_pick = 16'd20;
                5:       limit_pick = 16'd45;
                6:       limit_pick = 16'd120;
                7:       limit_pick = 16'($urandom_range(1, 65535));
                8:       limit_pick = pll_pkg::SCAN_LIMIT_RESET;
                default: limit_pick = 16'hFFFF;
            endcase
            write_limit(limit_pick);
            quiet = (p == PHASES - 1);
            case ($urandom_range(0, 2))
                0:       tx_idle_pct = 0;
                1:       tx_idle_pct = 10;
                default: tx_idle_pct = 30;
            endcase
            rx_idle_pct = (p % 3 == 1) ? 0 : $urandom_range(5, 30);
            phase_bytes = 0;
            while (phase_bytes < RANDOM_BYTES / PHASES) begin
                make_response();
                for (int j = 0; j < resp_q.size(); j++)
                    send_byte(resp_q[j], j == resp_q.size() - 1);
                phase_bytes += resp_q.size();
            end
        end

        s_valid <= 1'b0;
        drained = 0;
        while (pending_locates.size() != 0 && drained < DRAIN_LIMIT) begin
            @(negedge aclk);
            drained++;
        end
        if (pending_locates.size() != 0) begin
            $display("%0t: %0d words never arrived, next found=%0b pack_start=%0d", $time,
                     pending_locates.size(), pending_locates[0].found,
                     pending_locates[0].pack_start);
            fails++;
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (fails == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule
